// ===== hdl/fpalu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fpalu_pkg
// Operation codes shared by the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpalu_pkg;

  localparam int KIND_W = 4;

  localparam logic [KIND_W-1:0] KIND_ADD  = 4'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_DIV  = 4'd3;
  localparam logic [KIND_W-1:0] KIND_MIN  = 4'd4;
  localparam logic [KIND_W-1:0] KIND_MAX  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_INC  = 4'd6;
  localparam logic [KIND_W-1:0] KIND_DEC  = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ITOF = 4'd8;
  localparam logic [KIND_W-1:0] KIND_FTOI = 4'd9;

endpackage
`default_nettype wire

// ===== hdl/fixed_point_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed fixed-point ALU (Q24.8 by default): add, sub, mul, div,
// min, max, inc, dec, int-to-fixed and fixed-to-int, with compare flags.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+---------------------
//   in      | kind, operand_a, operand_b              | start & !busy
//   out     | result_raw, a_less, a_equal, a_greater, | done, one cycle,
//           | overflow, divide_by_zero                | cannot be held off
//
// Every item passes the entry register, the divider stages and the output
// register from start to done; the depth is set by the restoring divider, one
// quotient bit per stage. A new item enters in every cycle outside reset. busy is high
// only during reset. rst clears the valid bits; the datapath needs no reset.
// All kinds walk the same pipe, so results leave in input order.
// ----------------------------------------------------------------------------
module fixed_point_alu
  import fpalu_pkg::*;
#(
  parameter int FRAC_BITS = 8,
  parameter int WORD_BITS = 32
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  output logic                       busy,
  input  wire  [KIND_W-1:0]          kind,
  input  wire  signed [WORD_BITS-1:0] operand_a,
  input  wire  signed [WORD_BITS-1:0] operand_b,
  output logic                       done,
  output logic signed [WORD_BITS-1:0] result_raw,
  output logic                       a_less,
  output logic                       a_equal,
  output logic                       a_greater,
  output logic                       overflow,
  output logic                       divide_by_zero
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NW = W + F;        // dividend and quotient width
  localparam int PW = 2 * W;        // full product width
  localparam int MW = 2 * W + 1;    // magnitude width into the saturator
  localparam int H  = (W + 1) / 2;  // low half of a multiplier operand
  localparam int HB = W - H;        // high half

  localparam logic [W-1:0]  MAX_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] HALF    = (PW'(1) << F) >> 1;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              neg;      // sign of a product or quotient
    logic              neg_a;
    logic              dz;
    logic [W-1:0]      simp_res;
    logic              simp_ovf;
    logic [W-1:0]      mul_res;
    logic              mul_ovf;
  } side_t;

  // Apply a sign to an unsigned magnitude and saturate to the word range.
  function automatic logic [W:0] sat_mag(input logic neg, input logic [MW-1:0] m);
    logic big;
    logic [W-1:0] lo;
    big = (m[MW-1:W] != '0) ||
          (m[W-1] && (!neg || (m[W-2:0] != '0)));
    lo  = m[W-1:0];
    if (big) begin
      sat_mag = {1'b1, (neg ? MIN_NEG : MAX_POS)};
    end else begin
      sat_mag = {1'b0, (neg ? W'(-lo) : lo)};
    end
  endfunction

  // Accept is combinational: the pipe never stalls.
  assign busy = rst;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Entry: compare flags, the simple kinds, and operand magnitudes
  // --------------------------------------------------------------------------
  side_t        entry_next;
  logic [W-1:0] mag_a_next;
  logic [W-1:0] mag_b_next;

  always_comb begin
    logic [W:0]   s_add;
    logic [W:0]   s_sub;
    logic [W:0]   s_inc;
    logic [W:0]   s_dec;
    logic [F:0]   top;
    logic [W-1:0] ua;
    logic [W-1:0] ub;
    ua    = operand_a;
    ub    = operand_b;
    s_add = {ua[W-1], ua} + {ub[W-1], ub};
    s_sub = {ua[W-1], ua} - {ub[W-1], ub};
    s_inc = {ua[W-1], ua} + (W+1)'(1);
    s_dec = {ua[W-1], ua} - (W+1)'(1);
    top   = ua[W-1 -: F+1];

    entry_next          = '0;
    entry_next.valid    = accept;
    entry_next.kind     = kind;
    entry_next.lt       = operand_a < operand_b;
    entry_next.eq       = operand_a == operand_b;
    entry_next.gt       = operand_a > operand_b;
    entry_next.neg      = ua[W-1] ^ ub[W-1];
    entry_next.neg_a    = ua[W-1];
    entry_next.dz       = (ub == '0);

    case (kind)
      KIND_ADD: begin
        entry_next.simp_ovf = s_add[W] ^ s_add[W-1];
        entry_next.simp_res = entry_next.simp_ovf ? (s_add[W] ? MIN_NEG : MAX_POS)
                                                  : s_add[W-1:0];
      end
      KIND_SUB: begin
        entry_next.simp_ovf = s_sub[W] ^ s_sub[W-1];
        entry_next.simp_res = entry_next.simp_ovf ? (s_sub[W] ? MIN_NEG : MAX_POS)
                                                  : s_sub[W-1:0];
      end
      KIND_INC: begin
        entry_next.simp_ovf = s_inc[W] ^ s_inc[W-1];
        entry_next.simp_res = entry_next.simp_ovf ? MAX_POS : s_inc[W-1:0];
      end
      KIND_DEC: begin
        entry_next.simp_ovf = s_dec[W] ^ s_dec[W-1];
        entry_next.simp_res = entry_next.simp_ovf ? MIN_NEG : s_dec[W-1:0];
      end
      KIND_MIN: entry_next.simp_res = (operand_a < operand_b) ? ua : ub;
      KIND_MAX: entry_next.simp_res = (operand_a > operand_b) ? ua : ub;
      KIND_ITOF: begin
        // In range only when the bits shifted out all copy the sign.
        entry_next.simp_ovf = !((&top) || !(|top));
        entry_next.simp_res = entry_next.simp_ovf ? (ua[W-1] ? MIN_NEG : MAX_POS)
                                                  : (ua << F);
      end
      KIND_FTOI: entry_next.simp_res = W'(operand_a >>> F);
      default:   entry_next.simp_res = '0;
    endcase

    mag_a_next = ua[W-1] ? W'(-ua) : ua;
    mag_b_next = ub[W-1] ? W'(-ub) : ub;
  end

  side_t        entry;
  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.kind     <= entry_next.kind;
    entry.lt       <= entry_next.lt;
    entry.eq       <= entry_next.eq;
    entry.gt       <= entry_next.gt;
    entry.neg      <= entry_next.neg;
    entry.neg_a    <= entry_next.neg_a;
    entry.dz       <= entry_next.dz;
    entry.simp_res <= entry_next.simp_res;
    entry.simp_ovf <= entry_next.simp_ovf;
    entry.mul_res  <= entry_next.mul_res;
    entry.mul_ovf  <= entry_next.mul_ovf;
    mag_a          <= mag_a_next;
    mag_b          <= mag_b_next;
  end

  // --------------------------------------------------------------------------
  // Multiplier: partial products, sum with rounding half, shift and saturate
  // --------------------------------------------------------------------------
  logic [2*H-1:0]  pp00;
  logic [H+HB-1:0] pp01;
  logic [H+HB-1:0] pp10;
  logic [2*HB-1:0] pp11;
  logic            m1_neg;
  logic [PW-1:0]   prod;
  logic            m2_neg;
  logic [W-1:0]    mul_res;
  logic            mul_ovf;

  always_ff @(posedge clk) begin
    logic [W:0] sm;
    pp00   <= mag_a[H-1:0] * mag_b[H-1:0];
    pp01   <= mag_a[H-1:0] * mag_b[W-1:H];
    pp10   <= mag_a[W-1:H] * mag_b[H-1:0];
    pp11   <= mag_a[W-1:H] * mag_b[W-1:H];
    m1_neg <= entry.neg;

    prod   <= PW'(pp00) + (PW'(pp01) << H) + (PW'(pp10) << H)
            + (PW'(pp11) << (2 * H)) + HALF;
    m2_neg <= m1_neg;

    sm      = sat_mag(m2_neg, MW'(prod >> F));
    mul_res <= sm[W-1:0];
    mul_ovf <= sm[W];
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage; side data rides along
  // --------------------------------------------------------------------------
  side_t        sd      [NW];
  side_t        sd_next [NW];
  logic [W-1:0] rem     [NW];
  logic [W-1:0] rem_next[NW];
  logic [NW-1:0] quo     [NW];
  logic [NW-1:0] quo_next[NW];
  logic [NW-1:0] num     [NW];
  logic [NW-1:0] num_next[NW];
  logic [W-1:0] dvs     [NW];
  logic [W-1:0] dvs_next[NW];

  always_comb begin
    logic [W-1:0]  r_in;
    logic [NW-1:0] q_in;
    logic [NW-1:0] n_in;
    logic [W-1:0]  d_in;
    logic [W:0]    rs;
    logic          ge;
    for (int k = 0; k < NW; k++) begin
      if (k == 0) begin
        sd_next[k] = entry;
        r_in       = '0;
        q_in       = '0;
        n_in       = NW'(mag_a) << F;
        d_in       = mag_b;
      end else begin
        sd_next[k] = sd[k-1];
        r_in       = rem[k-1];
        q_in       = quo[k-1];
        n_in       = num[k-1];
        d_in       = dvs[k-1];
      end
      // The multiplier result lands three stages in.
      if (k == 3) begin
        sd_next[k].mul_res = mul_res;
        sd_next[k].mul_ovf = mul_ovf;
      end
      rs          = {r_in, n_in[NW-1]};
      ge          = rs >= {1'b0, d_in};
      rem_next[k] = ge ? W'(rs - {1'b0, d_in}) : rs[W-1:0];
      quo_next[k] = {q_in[NW-2:0], ge};
      num_next[k] = n_in << 1;
      dvs_next[k] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else begin
        sd[k].valid <= sd_next[k].valid;
      end
      sd[k].kind     <= sd_next[k].kind;
      sd[k].lt       <= sd_next[k].lt;
      sd[k].eq       <= sd_next[k].eq;
      sd[k].gt       <= sd_next[k].gt;
      sd[k].neg      <= sd_next[k].neg;
      sd[k].neg_a    <= sd_next[k].neg_a;
      sd[k].dz       <= sd_next[k].dz;
      sd[k].simp_res <= sd_next[k].simp_res;
      sd[k].simp_ovf <= sd_next[k].simp_ovf;
      sd[k].mul_res  <= sd_next[k].mul_res;
      sd[k].mul_ovf  <= sd_next[k].mul_ovf;
      rem[k]         <= rem_next[k];
      quo[k]         <= quo_next[k];
      num[k]         <= num_next[k];
      dvs[k]         <= dvs_next[k];
    end
  end

  // --------------------------------------------------------------------------
  // Output: round the quotient, pick the result by kind, register
  // --------------------------------------------------------------------------
  side_t        last;
  logic [W:0]   div_sm;
  logic [NW:0]  quo_rnd;
  logic         rnd_up;
  logic [W-1:0] res_next;
  logic         ovf_next;
  logic         dz_next;

  assign last = sd[NW-1];

  always_comb begin
    // Halves round away from zero: remainder at least half the divisor.
    rnd_up  = rem[NW-1] >= (dvs[NW-1] - rem[NW-1]);
    quo_rnd = (NW+1)'(quo[NW-1]) + (NW+1)'(rnd_up);
    div_sm  = sat_mag(last.neg, MW'(quo_rnd));

    res_next = last.simp_res;
    ovf_next = last.simp_ovf;
    dz_next  = 1'b0;
    case (last.kind)
      KIND_MUL: begin
        res_next = last.mul_res;
        ovf_next = last.mul_ovf;
      end
      KIND_DIV: begin
        if (last.dz) begin
          res_next = last.neg_a ? MIN_NEG : MAX_POS;
          ovf_next = 1'b0;
          dz_next  = 1'b1;
        end else begin
          res_next = div_sm[W-1:0];
          ovf_next = div_sm[W];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= last.valid;
    end
    result_raw     <= res_next;
    a_less         <= last.lt;
    a_equal        <= last.eq;
    a_greater      <= last.gt;
    overflow       <= ovf_next;
    divide_by_zero <= dz_next;
  end

endmodule
`default_nettype wire
